FILE: design/tmmb_pkg.sv
package tmmb_pkg;

    localparam int TMMB_DEPTH             = 32;
    localparam int TMMB_MAX_FRAME_SAMPLES = 16384;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [1:0] MODE_MEDIAN = 2'd0;
    localparam logic [1:0] MODE_LIGHT  = 2'd1;
    localparam logic [1:0] MODE_DARK   = 2'd2;
    localparam logic [1:0] MODE_MEAN   = 2'd3;

    localparam logic [1:0] CFG_FRAME_SAMPLES = 2'd0;
    localparam logic [1:0] CFG_BUFFER_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_REDUCE_MODE   = 2'd2;

    localparam int CFG_DATA_W = 15;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [13:0] sample_index;
        logic [7:0]  sample_value;
        logic        frame_end;
    } in_word_t;

    typedef struct packed {
        logic [7:0] result_value;
        logic [1:0] status;
    } out_word_t;

endpackage

FILE: design/tmmb_div.sv
module tmmb_div #(
    parameter int NUM_W = 14,
    parameter int DEN_W = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    // One quotient bit per cycle, restoring form.
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(NUM_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= den;
            quo_reg <= num;
        end
        else if (run_reg)
        begin
            if (fits)
            begin
                rem_reg <= DEN_W'(trial - {1'b0, den_reg});
            end
            else
            begin
                rem_reg <= trial[DEN_W-1:0];
            end
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

FILE: design/temporal_median_mean_background.sv
// Temporal median / mean background estimator.
// Input channel (in_valid, in_stall, in_word) carries push, query and clear
// words; the output channel (out_valid, out_stall, out_word) returns exactly
// one word for every input word, in order.
// A push or clear answers directly from the idle state. A query with an empty
// series or a bad index answers the same way. A valid query reads the n stored
// samples of that index from the frame memory, one per cycle, while inserting
// them into a sorted register row. The median then passes through S_MED0, and
// for an even n also S_MED1; a biased median passes S_HI and then walks one
// rank step per cycle in S_WALK, and the mean waits on a bit-serial division.
// The S_OUT state hands the result to the output register.
// One word is worked on at a time; in_stall is high while a query is in work
// or while a finished word waits and out_stall is high.
// Reset empties the series and restores the register defaults; the frame
// memory itself is not cleared, so samples never pushed read as anything.
// Configuration writes are taken at any edge with cfg_we high.
module temporal_median_mean_background
    import tmmb_pkg::*;
#(
    parameter int DEPTH             = TMMB_DEPTH,
    parameter int MAX_FRAME_SAMPLES = TMMB_MAX_FRAME_SAMPLES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  tmmb_pkg::in_word_t          in_word,
    output logic                        out_valid,
    input  logic                        out_stall,
    output tmmb_pkg::out_word_t         out_word,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [tmmb_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tmmb_pkg::*;

    localparam int SLOTS  = DEPTH + 1;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W  = 8 + CNT_W;
    localparam int MW     = CNT_W + 2;
    localparam int ADDR_W = $clog2(SLOTS * MAX_FRAME_SAMPLES);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_MED0 = 3'd2;
    localparam logic [2:0] S_MED1 = 3'd3;
    localparam logic [2:0] S_HI   = 3'd4;
    localparam logic [2:0] S_WALK = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [7:0] mem [SLOTS * MAX_FRAME_SAMPLES];
    logic [7:0] rdata_reg;

    logic [14:0]       fs_reg;
    logic [5:0]        bl_reg;
    logic [1:0]        mode_reg;
    logic [CNT_W-1:0]  fc_reg;
    logic [SLOT_W-1:0] oldest_reg;
    logic [SLOT_W-1:0] staging_reg;

    logic [2:0]        state_reg;
    logic [13:0]       qidx_reg;
    logic [SLOT_W-1:0] rslot_reg;
    logic [CNT_W-1:0]  iss_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  n_reg;
    logic              cap_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [7:0]        s_reg [DEPTH];
    logic [7:0]        s_next [DEPTH];
    logic signed [MW-1:0] m_reg;
    logic [7:0]        a_reg;
    logic [7:0]        hi_reg;
    logic [7:0]        res_reg;
    logic              out_valid_reg;
    out_word_t         out_word_reg;

    logic              out_free;
    logic              accept;
    logic              idx_ok;
    logic              query_go;
    logic              out_load;
    logic [1:0]        imm_status;
    logic [CNT_W-1:0]  lim;
    logic [CNT_W-1:0]  drop;
    logic [SLOT_W:0]   old_sum;
    logic              mem_we;
    logic              mem_re;
    logic [SLOT_W-1:0] mem_slot;
    logic [13:0]       mem_idx;
    logic [ADDR_W-1:0] mem_addr;
    logic [DEPTH-1:0]  le;
    logic [SUM_W-1:0]  sum_next;
    logic              last_cap;
    logic [IDX_W-1:0]  rd_idx;
    logic [7:0]        rd_val;
    logic [7:0]        dl;
    logic [7:0]        dh;
    logic              go;
    logic signed [MW-1:0] m_step;
    logic signed [MW-1:0] minr;
    logic signed [MW-1:0] maxr;
    logic              div_start;
    logic              div_done;
    logic [SUM_W-1:0]  div_quo;
    logic [8:0]        avg;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE) || !out_free;
    assign accept   = in_valid && !in_stall;

    assign idx_ok = (32'(in_word.sample_index) < 32'(fs_reg))
                 && (32'(in_word.sample_index) < 32'(MAX_FRAME_SAMPLES));

    // Only a query with stored frames and a good index goes to the memory.
    assign query_go = (in_word.opcode == OP_QUERY) && (fc_reg != '0) && idx_ok;
    assign out_load = ((state_reg == S_IDLE) && accept && !query_go)
                   || ((state_reg == S_OUT) && out_free);

    always_comb
    begin
        case (in_word.opcode)
            OP_PUSH:  imm_status = idx_ok ? ST_OK : ST_RANGE;
            OP_QUERY: imm_status = (fc_reg == '0) ? ST_EMPTY : ST_RANGE;
            default:  imm_status = ST_OK;
        endcase
    end

    assign lim = (bl_reg == 6'd0 || 32'(bl_reg) > 32'(DEPTH)) ? CNT_W'(DEPTH)
                                                               : CNT_W'(bl_reg);
    assign drop    = fc_reg - (lim - 1'b1);
    assign old_sum = {1'b0, oldest_reg} + (SLOT_W + 1)'(drop);

    // Frame memory: one port, written by pushes, read while a query loads.
    assign mem_we   = accept && (in_word.opcode == OP_PUSH) && idx_ok;
    assign mem_re   = (state_reg == S_LOAD) && (iss_reg < n_reg);
    assign mem_slot = (state_reg == S_LOAD) ? rslot_reg : staging_reg;
    assign mem_idx  = (state_reg == S_LOAD) ? qidx_reg : in_word.sample_index;
    assign mem_addr = ADDR_W'(mem_slot) * ADDR_W'(MAX_FRAME_SAMPLES) + ADDR_W'(mem_idx);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= in_word.sample_value;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    // Sorted insertion: entries not above the new sample stay, the rest shift up.
    always_comb
    begin
        for (int j = 0; j < DEPTH; j++)
        begin
            le[j] = (CNT_W'(j) < cnt_reg) && (s_reg[j] <= rdata_reg);
        end
        for (int j = 0; j < DEPTH; j++)
        begin
            if (le[j])
            begin
                s_next[j] = s_reg[j];
            end
            else if (j == 0)
            begin
                s_next[j] = rdata_reg;
            end
            else if (le[j-1])
            begin
                s_next[j] = rdata_reg;
            end
            else
            begin
                s_next[j] = s_reg[j-1];
            end
        end
    end

    assign sum_next = sum_reg + SUM_W'(rdata_reg);
    assign last_cap = cap_reg && (cnt_reg + 1'b1 == n_reg);

    assign rd_idx = (state_reg == S_HI) ? IDX_W'(n_reg - 1'b1) : IDX_W'(m_reg);
    assign rd_val = s_reg[rd_idx];
    assign avg    = (9'(a_reg) + 9'(rd_val)) >> 1;

    // Rank bounds round(0.01 n) and round(0.99 n) for n up to 64.
    assign minr = (32'(n_reg) >= 32'd50) ? MW'(1) : MW'(0);
    assign maxr = MW'(n_reg) - ((32'(n_reg) > 32'd50) ? MW'(1) : MW'(0));

    assign dl = rd_val - s_reg[0];
    assign dh = hi_reg - rd_val;
    assign go = (mode_reg == MODE_LIGHT) ? (12'(dl) < 12'(dh) * 12'd10)
                                         : (12'(dh) < 12'(dl) * 12'd10);
    assign m_step = (mode_reg == MODE_LIGHT) ? m_reg + MW'(1) : m_reg - MW'(1);

    assign div_start = (state_reg == S_LOAD) && last_cap && (mode_reg == MODE_MEAN);

    tmmb_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (sum_next),
        .den   (n_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
            if (state_reg == S_OUT)
            begin
                out_word_reg.result_value <= res_reg;
                out_word_reg.status       <= ST_OK;
            end
            else
            begin
                out_word_reg.result_value <= '0;
                out_word_reg.status       <= imm_status;
            end
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg        <= 15'd16384;
            bl_reg        <= '0;
            mode_reg      <= MODE_MEDIAN;
            fc_reg        <= '0;
            oldest_reg    <= '0;
            staging_reg   <= '0;
            state_reg     <= S_IDLE;
            cap_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FRAME_SAMPLES: fs_reg   <= cfg_data;
                    CFG_BUFFER_LIMIT:  bl_reg   <= cfg_data[5:0];
                    CFG_REDUCE_MODE:   mode_reg <= cfg_data[1:0];
                    default:           ;
                endcase
            end

            cap_reg <= mem_re;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (in_word.opcode)
                            OP_PUSH:
                            begin
                                if (in_word.frame_end)
                                begin
                                    if (fc_reg >= lim)
                                    begin
                                        oldest_reg <= (old_sum >= (SLOT_W + 1)'(SLOTS))
                                            ? SLOT_W'(old_sum - (SLOT_W + 1)'(SLOTS))
                                            : SLOT_W'(old_sum);
                                        fc_reg <= lim;
                                    end
                                    else
                                    begin
                                        fc_reg <= fc_reg + 1'b1;
                                    end
                                    staging_reg <= (32'(staging_reg) == SLOTS - 1)
                                        ? '0 : staging_reg + 1'b1;
                                end
                            end
                            OP_QUERY:
                            begin
                                if (query_go)
                                begin
                                    state_reg <= S_LOAD;
                                    qidx_reg  <= in_word.sample_index;
                                    rslot_reg <= oldest_reg;
                                    n_reg     <= fc_reg;
                                    iss_reg   <= '0;
                                    cnt_reg   <= '0;
                                    sum_reg   <= '0;
                                end
                            end
                            OP_CLEAR:
                            begin
                                fc_reg        <= '0;
                                oldest_reg    <= '0;
                                staging_reg   <= '0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_LOAD:
                begin
                    if (mem_re)
                    begin
                        iss_reg   <= iss_reg + 1'b1;
                        rslot_reg <= (32'(rslot_reg) == SLOTS - 1) ? '0 : rslot_reg + 1'b1;
                    end
                    if (cap_reg)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        sum_reg <= sum_next;
                    end
                    if (last_cap)
                    begin
                        // Start rank: the lower middle element.
                        m_reg <= MW'((n_reg - 1'b1) >> 1);
                        case (mode_reg)
                            MODE_MEDIAN: state_reg <= S_MED0;
                            MODE_MEAN:   state_reg <= S_DIV;
                            default:     state_reg <= S_HI;
                        endcase
                    end
                end
                S_MED0:
                begin
                    if (n_reg[0])
                    begin
                        res_reg   <= rd_val;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        a_reg     <= rd_val;
                        m_reg     <= m_reg + MW'(1);
                        state_reg <= S_MED1;
                    end
                end
                S_MED1:
                begin
                    res_reg   <= avg[7:0];
                    state_reg <= S_OUT;
                end
                S_HI:
                begin
                    hi_reg    <= rd_val;
                    state_reg <= S_WALK;
                end
                S_WALK:
                begin
                    if (go && (m_step >= minr) && (m_step < maxr))
                    begin
                        m_reg <= m_step;
                    end
                    else
                    begin
                        res_reg   <= rd_val;
                        state_reg <= S_OUT;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        res_reg   <= div_quo[7:0];
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOAD && cap_reg)
        begin
            s_reg <= s_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule
